FILE: hdl/lrgc_pkg.sv
// Shared types and constants for the lidar return to grid cell block.
// No dependencies; used by every module under hdl/.
package lrgc_pkg;

    // CORDIC datapath widths: x/y carry range*256 times the CORDIC gain.
    localparam int XW     = 27;
    localparam int ZW     = 17;
    localparam int ITERS  = 14;
    // Q8 cell coordinate out of the scaler, before the offset is added.
    localparam int CW     = 26;
    localparam int OFS_W  = 24;
    localparam int CNT_W  = 12;
    localparam int SCALE_STAGES = 4;

    localparam logic signed [ZW-1:0] ATAN_TAB [ITERS] = '{
        17'sd8192, 17'sd4836, 17'sd2555, 17'sd1297, 17'sd651, 17'sd326, 17'sd163,
        17'sd81,   17'sd41,   17'sd20,   17'sd10,   17'sd5,   17'sd3,   17'sd1
    };

    // Cell scaling: floor(v * 39797 * cpm / (2^27 * 125)).
    // The divide by 125 runs on a biased, non-negative value through a
    // reciprocal that is exact for operands below 2^31.
    localparam logic [15:0] CELL_GAIN   = 16'd39797;
    localparam logic [29:0] DIV_BIAS    = 30'd1048576000;   // 125 * 2^23
    localparam logic [31:0] RECIP_125   = 32'd2199023256;   // ceil(2^38 / 125)
    localparam int          RECIP_SHIFT = 38;
    localparam logic signed [CW-1:0] QUOT_BIAS = 26'sd8388608;  // DIV_BIAS / 125

    // Quadrant codes after the +45 degree fold.
    localparam logic [1:0] QUAD_0   = 2'd0;
    localparam logic [1:0] QUAD_90  = 2'd1;
    localparam logic [1:0] QUAD_180 = 2'd2;
    localparam logic [1:0] QUAD_270 = 2'd3;

    typedef enum logic [3:0] {
        CFG_START_HEADING = 4'd0,
        CFG_HEADING_STEP  = 4'd1,
        CFG_RANGE_MIN     = 4'd2,
        CFG_RANGE_MAX     = 4'd3,
        CFG_CELLS_PER_M   = 4'd4,
        CFG_OFFSET_X      = 4'd5,
        CFG_OFFSET_Y      = 4'd6,
        CFG_CELL_COUNT    = 4'd7
    } t_cfg_idx;

    typedef struct packed {
        logic       valid;
        logic       range_ok;
        logic       last;
        logic [1:0] quad;
    } t_side;

    typedef struct packed {
        logic             hit;
        logic [CNT_W-1:0] col;
        logic [CNT_W-1:0] row;
        logic             scan_end;
    } t_result;

endpackage

FILE: hdl/lrgc_cordic_stage.sv
// One registered CORDIC rotation step with a fixed shift.
// Depends on lrgc_pkg for widths and the arctangent table.
module lrgc_cordic_stage #(
    parameter int unsigned STEP = 0
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [lrgc_pkg::XW-1:0] i_x,
    input  logic signed [lrgc_pkg::XW-1:0] i_y,
    input  logic signed [lrgc_pkg::ZW-1:0] i_z,
    output logic signed [lrgc_pkg::XW-1:0] o_x,
    output logic signed [lrgc_pkg::XW-1:0] o_y,
    output logic signed [lrgc_pkg::ZW-1:0] o_z
);

    logic signed [lrgc_pkg::XW-1:0] r_x, n_x;
    logic signed [lrgc_pkg::XW-1:0] r_y, n_y;
    logic signed [lrgc_pkg::ZW-1:0] r_z, n_z;

    always_comb begin
        if (!i_z[lrgc_pkg::ZW-1]) begin
            n_x = i_x - (i_y >>> STEP);
            n_y = i_y + (i_x >>> STEP);
            n_z = i_z - lrgc_pkg::ATAN_TAB[STEP];
        end else begin
            n_x = i_x + (i_y >>> STEP);
            n_y = i_y - (i_x >>> STEP);
            n_z = i_z + lrgc_pkg::ATAN_TAB[STEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

FILE: hdl/lrgc_axis_scale.sv
// Four-stage scaler: CORDIC units to Q8 cells, floor(v*39797*cpm/16777216000).
// Depends on lrgc_pkg for widths and scaling constants.
module lrgc_axis_scale (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [lrgc_pkg::XW-1:0] i_v,
    input  logic        [15:0]            i_cpm,
    output logic signed [lrgc_pkg::CW-1:0] o_c
);

    logic signed [43:0] r_p, n_p;
    logic signed [39:0] r_ahi, n_ahi;
    logic        [36:0] r_alo, n_alo;
    logic signed [61:0] w_sum;
    logic        [30:0] r_m;
    logic        [62:0] w_prod;
    logic signed [lrgc_pkg::CW-1:0] r_c, n_c;

    assign n_p = i_v * $signed({1'b0, i_cpm});

    // Split the 44-bit product so each gain multiply stays narrow.
    assign n_ahi = $signed(r_p[43:21]) * $signed({1'b0, lrgc_pkg::CELL_GAIN});
    assign n_alo = r_p[20:0] * lrgc_pkg::CELL_GAIN;

    // Recombine, add the divide bias and floor by 2^27 (mm to m share + Q8).
    assign w_sum = (62'(r_ahi) <<< 21) + $signed({25'b0, r_alo})
                 + $signed({5'b0, lrgc_pkg::DIV_BIAS, 27'b0});

    assign w_prod = r_m * lrgc_pkg::RECIP_125;
    assign n_c    = $signed({1'b0, w_prod[62:lrgc_pkg::RECIP_SHIFT]}) - lrgc_pkg::QUOT_BIAS;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p   <= n_p;
            r_ahi <= n_ahi;
            r_alo <= n_alo;
            r_m   <= w_sum[57:27];
            r_c   <= n_c;
        end
    end

    assign o_c = r_c;

endmodule

FILE: hdl/lidar_return_to_grid_cell.sv
// Top level: maps one lidar range sample to a square occupancy grid cell.
// Depends on lrgc_pkg, lrgc_cordic_stage and lrgc_axis_scale.
//
// Usage:
//   Input channel: i_in_valid / o_in_stall carry one item per beam
//   (range in mm, beam index, last-beam flag). Output channel:
//   o_out_valid / i_out_stall carry one result item per input item
//   (hit, cell column, cell row, scan end), in input order.
//   An item moves at a clock edge with valid high and stall low.
//   Throughput: one item per cycle while the skid is empty. Path to the
//   output: heading multiply, CORDIC setup, 14 CORDIC stages, 4 scaling
//   stages (two multiplies, a wide add and a reciprocal divide by 125) and
//   the grid compare.
//   The output register is backed by a one-item skid buffer; o_in_stall
//   is the skid-full flag, so the pipeline freezes only once a result is
//   held in the skid while the receiver stalls, and starts again as soon
//   as that result drains. No item is lost or repeated across a stall.
//   Reset (synchronous, active low) empties the pipeline and loads the
//   configuration registers with their defaults; configuration is written
//   through i_cfg_wr_en / i_cfg_index / i_cfg_data while the block is idle.
module lidar_return_to_grid_cell #(
    parameter int INDEX_BITS = 12,
    parameter int ANGLE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_wr_en,
    input  logic [3:0]            i_cfg_index,
    input  logic [23:0]           i_cfg_data,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [15:0]           i_range_mm,
    input  logic [INDEX_BITS-1:0] i_beam_index,
    input  logic                  i_last_beam,
    // output channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_hit,
    output logic [11:0]           o_cell_col,
    output logic [11:0]           o_cell_row,
    output logic                  o_scan_end
);

    localparam int XW    = lrgc_pkg::XW;
    localparam int ZW    = lrgc_pkg::ZW;
    localparam int CW    = lrgc_pkg::CW;
    localparam int ITERS = lrgc_pkg::ITERS;
    localparam int SST   = lrgc_pkg::SCALE_STAGES;
    localparam int HSW   = INDEX_BITS + 17;     // heading sum, wide enough for the product plus start heading
    localparam int TW    = CW + 1;              // Q8 cell plus offset
    localparam logic signed [ZW-1:0] Z_RESID_LIM = ZW'(64);

    // ---------------- configuration registers ----------------
    logic [15:0]                       r_start_heading;
    logic [15:0]                       r_heading_step;   // used as raw 16 bits
    logic [15:0]                       r_range_min;
    logic [15:0]                       r_range_max;
    logic [15:0]                       r_cells_per_m;
    logic signed [lrgc_pkg::OFS_W-1:0] r_offset_x;
    logic signed [lrgc_pkg::OFS_W-1:0] r_offset_y;
    logic [lrgc_pkg::CNT_W-1:0]        r_cell_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_heading <= 16'd0;
            r_heading_step  <= 16'd64;
            r_range_min     <= 16'd100;
            r_range_max     <= 16'd20000;
            r_cells_per_m   <= 16'd2560;
            r_offset_x      <= 24'sd51456;
            r_offset_y      <= 24'sd51456;
            r_cell_count    <= 12'd401;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                lrgc_pkg::CFG_START_HEADING: r_start_heading <= i_cfg_data[15:0];
                lrgc_pkg::CFG_HEADING_STEP:  r_heading_step  <= i_cfg_data[15:0];
                lrgc_pkg::CFG_RANGE_MIN:     r_range_min     <= i_cfg_data[15:0];
                lrgc_pkg::CFG_RANGE_MAX:     r_range_max     <= i_cfg_data[15:0];
                lrgc_pkg::CFG_CELLS_PER_M:   r_cells_per_m   <= i_cfg_data[15:0];
                lrgc_pkg::CFG_OFFSET_X:      r_offset_x      <= $signed(i_cfg_data);
                lrgc_pkg::CFG_OFFSET_Y:      r_offset_y      <= $signed(i_cfg_data);
                lrgc_pkg::CFG_CELL_COUNT:    r_cell_count    <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline enable ----------------
    // Whole pipeline advances unless the skid holds a result.
    logic r_sv;
    logic w_en;
    assign w_en       = !r_sv;
    assign o_in_stall = r_sv;

    // ---------------- stage 1: heading and range gate ----------------
    logic [INDEX_BITS+15:0] w_prod;
    logic [HSW-1:0]         w_hsum;
    logic [ANGLE_BITS-1:0]  w_h;
    logic [15:0]            w_h16;
    logic                   n_s1_ok;

    // Heading wraps modulo a full turn; step is taken as raw unsigned bits.
    assign w_prod = i_beam_index * r_heading_step;
    assign w_hsum = HSW'(w_prod) + HSW'(r_start_heading);
    assign w_h    = w_hsum[ANGLE_BITS-1:0];

    if (ANGLE_BITS >= 16) begin : g_h_down
        assign w_h16 = w_h[ANGLE_BITS-1 -: 16];
    end else begin : g_h_up
        assign w_h16 = {w_h, {(16 - ANGLE_BITS){1'b0}}};
    end

    assign n_s1_ok = (i_range_mm != 16'd0) && (i_range_mm >= r_range_min)
                   && (i_range_mm <= r_range_max);

    logic        r_s1_valid, r_s1_ok, r_s1_last;
    logic [15:0] r_s1_h16, r_s1_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_ok    <= n_s1_ok;
            r_s1_last  <= i_last_beam;
            r_s1_h16   <= w_h16;
            r_s1_range <= i_range_mm;
        end
    end

    // ---------------- stage 2: fold to +-45 degrees ----------------
    logic [15:0]            w_u;
    lrgc_pkg::t_side        n_s2_side, r_s2_side;
    logic signed [XW-1:0]   r_s2_x;
    logic signed [ZW-1:0]   r_s2_z, n_s2_z;

    assign w_u    = r_s1_h16 + 16'h2000;
    assign n_s2_z = $signed({3'b000, w_u[13:0]}) - ZW'(8192);

    always_comb begin
        n_s2_side.valid    = r_s1_valid;
        n_s2_side.range_ok = r_s1_ok;
        n_s2_side.last     = r_s1_last;
        n_s2_side.quad     = w_u[15:14];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_side <= '0;
        end else if (w_en) begin
            r_s2_side <= n_s2_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_x <= $signed({3'b000, r_s1_range, 8'h00});
            r_s2_z <= n_s2_z;
        end
    end

    // ---------------- CORDIC chain, one iteration per stage ----------------
    logic signed [XW-1:0] w_cx [ITERS+1];
    logic signed [XW-1:0] w_cy [ITERS+1];
    logic signed [ZW-1:0] w_cz [ITERS+1];
    lrgc_pkg::t_side      r_cside [ITERS];

    assign w_cx[0] = r_s2_x;
    assign w_cy[0] = '0;
    assign w_cz[0] = r_s2_z;

    for (genvar k = 0; k < ITERS; k++) begin : g_cordic
        lrgc_cordic_stage #(
            .STEP (k)
        ) u_stage (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_x   (w_cx[k]),
            .i_y   (w_cy[k]),
            .i_z   (w_cz[k]),
            .o_x   (w_cx[k+1]),
            .o_y   (w_cy[k+1]),
            .o_z   (w_cz[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ITERS; k++) begin
                r_cside[k] <= '0;
            end
        end else if (w_en) begin
            r_cside[0] <= r_s2_side;
            for (int k = 1; k < ITERS; k++) begin
                r_cside[k] <= r_cside[k-1];
            end
        end
    end

    // ---------------- quadrant rotation into the scalers ----------------
    logic signed [XW-1:0] w_vx, w_vy;

    always_comb begin
        case (r_cside[ITERS-1].quad)
            lrgc_pkg::QUAD_0: begin
                w_vx = w_cx[ITERS];
                w_vy = w_cy[ITERS];
            end
            lrgc_pkg::QUAD_90: begin
                w_vx = -w_cy[ITERS];
                w_vy = w_cx[ITERS];
            end
            lrgc_pkg::QUAD_180: begin
                w_vx = -w_cx[ITERS];
                w_vy = -w_cy[ITERS];
            end
            lrgc_pkg::QUAD_270: begin
                w_vx = w_cy[ITERS];
                w_vy = -w_cx[ITERS];
            end
            default: begin
                w_vx = w_cx[ITERS];
                w_vy = w_cy[ITERS];
            end
        endcase
    end

    logic signed [CW-1:0] w_cx_q8, w_cy_q8;
    lrgc_pkg::t_side      r_sside [SST];

    lrgc_axis_scale u_scale_x (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_v   (w_vx),
        .i_cpm (r_cells_per_m),
        .o_c   (w_cx_q8)
    );

    lrgc_axis_scale u_scale_y (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_v   (w_vy),
        .i_cpm (r_cells_per_m),
        .o_c   (w_cy_q8)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SST; k++) begin
                r_sside[k] <= '0;
            end
        end else if (w_en) begin
            r_sside[0] <= r_cside[ITERS-1];
            for (int k = 1; k < SST; k++) begin
                r_sside[k] <= r_sside[k-1];
            end
        end
    end

    // ---------------- offset, floor to cell, grid test ----------------
    logic signed [TW-1:0]        w_tx, w_ty;
    logic [TW-9:0]               w_col, w_row;   // sign bit on top
    logic                        w_in_grid;
    lrgc_pkg::t_result           n_res;
    logic                        w_nv;

    assign w_tx  = TW'(w_cx_q8) + TW'(r_offset_x);
    assign w_ty  = TW'(w_cy_q8) + TW'(r_offset_y);
    assign w_col = w_tx[TW-1:8];
    assign w_row = w_ty[TW-1:8];

    // Floor by 256 is the upper bits; negative means the sign bit is set.
    assign w_in_grid = !w_col[TW-9] && !w_row[TW-9]
                    && (w_col < (TW-8)'(r_cell_count))
                    && (w_row < (TW-8)'(r_cell_count));

    always_comb begin
        n_res.hit      = r_sside[SST-1].range_ok && w_in_grid;
        n_res.col      = n_res.hit ? w_col[11:0] : 12'd0;
        n_res.row      = n_res.hit ? w_row[11:0] : 12'd0;
        n_res.scan_end = r_sside[SST-1].last;
    end

    assign w_nv = r_sside[SST-1].valid;

    // ---------------- output register and skid ----------------
    logic              r_ov;
    lrgc_pkg::t_result r_od, r_sd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (!i_out_stall) begin
                r_ov <= 1'b1;
                r_sv <= 1'b0;
            end
        end else if (!r_ov || !i_out_stall) begin
            r_ov <= w_nv;
        end else if (w_nv) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (!i_out_stall) begin
                r_od <= r_sd;
            end
        end else if (!r_ov || !i_out_stall) begin
            r_od <= n_res;
        end else begin
            r_sd <= n_res;
        end
    end

    assign o_out_valid = r_ov;
    assign o_hit       = r_od.hit;
    assign o_cell_col  = r_od.col;
    assign o_cell_row  = r_od.row;
    assign o_scan_end  = r_od.scan_end;

    // ---------------- assertions ----------------
    // skid holds data only behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid full while output register empty");

    // skid fills only when the receiver stalled a waiting result
    a_skid_fill_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sv) |-> $past(r_ov && i_out_stall))
        else $error("skid filled without an output stall");

    // CORDIC residual angle must have converged by the last stage
    a_cordic_resid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cside[ITERS-1].valid |->
            (w_cz[ITERS] < Z_RESID_LIM && w_cz[ITERS] > -Z_RESID_LIM))
        else $error("CORDIC residual angle out of range");

    // a miss reports cell zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_od.hit) |-> (o_cell_col == 12'd0 && o_cell_row == 12'd0))
        else $error("miss result carries a nonzero cell");

endmodule
